/* rtl/qdar_pkg.sv */
package qdar_pkg;

  localparam int QUAT_W     = 16;
  localparam int STAMP_W    = 40;
  localparam int DATA_W     = 32;
  localparam int COV_OUT_W  = 48;
  localparam int MUL_W      = 35;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = 80;
  localparam int DIV_W      = 72;
  localparam int SQRT_IN_W  = 62;
  localparam int ROOT_W     = 31;
  localparam int VA_W       = 31;
  localparam int XY_W       = 64;
  localparam int Z_W        = 36;
  localparam int R_W        = 54;
  localparam int U_W        = 25;
  localparam int MUL_SPLIT  = 34;
  localparam int RATE_SHIFT = 39;
  localparam int CORDIC_STEPS = 32;
  localparam int CNT_W      = 7;

  localparam int SQRT_STEPS = SQRT_IN_W / 2;
  localparam int QMUL_TERMS = 16;

  localparam int ADDR_W = 3;
  localparam logic [0:0] REG_DIFF_MODE = 1'b0;

  localparam logic signed [QUAT_W-1:0] Q_ONE     = 16'sd16384;
  localparam logic signed [QUAT_W-1:0] Q_NEG_ONE = -16'sd16384;

  localparam logic [MUL_W-1:0] US_PER_S = MUL_W'(1000000);
  localparam logic [40:0]      COV_GAIN = 41'd2000000000000;

  typedef struct packed {
    logic signed [QUAT_W-1:0]  quat_x;
    logic signed [QUAT_W-1:0]  quat_y;
    logic signed [QUAT_W-1:0]  quat_z;
    logic signed [QUAT_W-1:0]  quat_w;
    logic        [STAMP_W-1:0] stamp_us;
    logic signed [DATA_W-1:0]  cov_first;
    logic signed [DATA_W-1:0]  cov_second;
    logic signed [DATA_W-1:0]  cov_third;
    logic signed [DATA_W-1:0]  rate_in_x;
    logic signed [DATA_W-1:0]  rate_in_y;
    logic signed [DATA_W-1:0]  rate_in_z;
  } sample_t;

  typedef struct packed {
    logic        [STAMP_W-1:0]   out_stamp_us;
    logic signed [DATA_W-1:0]    rate_out_x;
    logic signed [DATA_W-1:0]    rate_out_y;
    logic signed [DATA_W-1:0]    rate_out_z;
    logic signed [COV_OUT_W-1:0] rate_cov_x;
    logic signed [COV_OUT_W-1:0] rate_cov_y;
    logic signed [COV_OUT_W-1:0] rate_cov_z;
  } result_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_COMMIT,
    OP_QMUL,
    OP_QFIN,
    OP_NORM,
    OP_SQ,
    OP_SQRT_INIT,
    OP_SQRT,
    OP_CORDIC_INIT,
    OP_CORDIC,
    OP_ZMUL,
    OP_DIV_R_INIT,
    OP_DIV_U_INIT,
    OP_DIV_C_INIT,
    OP_DIV_C2_INIT,
    OP_DIV,
    OP_SAVE_R,
    OP_UMUL_LO,
    OP_UMUL_HI,
    OP_RATE_SAT,
    OP_RATE_ZERO,
    OP_CMUL_LO,
    OP_CMUL_HI,
    OP_COV_SAT,
    OP_EMIT,
    OP_EMIT_DIRECT
  } dp_op_t;

  typedef struct packed {
    dp_op_t           op;
    logic [CNT_W-1:0] idx;
    logic [1:0]       sel;
  } dp_cmd_t;

  typedef struct packed {
    logic cov_neg;
    logic have_prev;
    logic dt_zero;
    logic vmax_zero;
    logic norm_done;
    logic out_free;
  } dp_status_t;

  typedef enum logic [2:0] {
    T_NONE,
    T_DQ,
    T_SUM,
    T_SET,
    T_ADDHI
  } tag_kind_t;

  typedef struct packed {
    tag_kind_t  kind;
    logic [1:0] comp;
    logic       neg;
  } ptag_t;

  typedef struct packed {
    logic [1:0] pi;
    logic [1:0] ci;
    logic       neg;
  } qterm_t;

  typedef logic [CORDIC_STEPS-1:0][31:0] atan_lut_t;

  // One term of conj(p) * c; the destination component is the upper two index bits.
  function automatic qterm_t qterm(input logic [3:0] k);
    qterm_t t;
    case (k)
      4'd0:    t = '{pi: 2'd3, ci: 2'd0, neg: 1'b0};
      4'd1:    t = '{pi: 2'd0, ci: 2'd3, neg: 1'b1};
      4'd2:    t = '{pi: 2'd1, ci: 2'd2, neg: 1'b1};
      4'd3:    t = '{pi: 2'd2, ci: 2'd1, neg: 1'b0};
      4'd4:    t = '{pi: 2'd3, ci: 2'd1, neg: 1'b0};
      4'd5:    t = '{pi: 2'd0, ci: 2'd2, neg: 1'b0};
      4'd6:    t = '{pi: 2'd1, ci: 2'd3, neg: 1'b1};
      4'd7:    t = '{pi: 2'd2, ci: 2'd0, neg: 1'b1};
      4'd8:    t = '{pi: 2'd3, ci: 2'd2, neg: 1'b0};
      4'd9:    t = '{pi: 2'd0, ci: 2'd1, neg: 1'b1};
      4'd10:   t = '{pi: 2'd1, ci: 2'd0, neg: 1'b0};
      4'd11:   t = '{pi: 2'd2, ci: 2'd3, neg: 1'b1};
      4'd12:   t = '{pi: 2'd3, ci: 2'd3, neg: 1'b0};
      4'd13:   t = '{pi: 2'd0, ci: 2'd0, neg: 1'b0};
      4'd14:   t = '{pi: 2'd1, ci: 2'd1, neg: 1'b0};
      default: t = '{pi: 2'd2, ci: 2'd2, neg: 1'b0};
    endcase
    return t;
  endfunction

  function automatic logic signed [QUAT_W-1:0] clamp_q(input logic signed [QUAT_W-1:0] v);
    logic signed [QUAT_W-1:0] r;
    r = v;
    if (v > Q_ONE) r = Q_ONE;
    if (v < Q_NEG_ONE) r = Q_NEG_ONE;
    return r;
  endfunction

  // Step angles atan(2^-k) in units of 2^-32 rad, from the alternating series in Q0.62.
  function automatic atan_lut_t build_atan();
    atan_lut_t   lut;
    logic [63:0] acc;
    logic [63:0] term;
    int          e;
    for (int k = 0; k < CORDIC_STEPS; k++) begin
      acc = '0;
      for (int j = 0; j < 32; j++) begin
        e = k * (2 * j + 1);
        if (k != 0 && e <= 62) begin
          term = (64'd1 << (62 - e)) / 64'(2 * j + 1);
          if (j % 2 == 1) acc = acc - term;
          else acc = acc + term;
        end
      end
      if (k == 0) lut[k] = 32'd3373259426;
      else lut[k] = 32'((acc + (64'd1 << 29)) >> 30);
    end
    return lut;
  endfunction

  localparam atan_lut_t ATAN_LUT = build_atan();

endpackage

/* rtl/qdar_ctrl.sv */
module qdar_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  input  logic                   differential_mode,
  input  qdar_pkg::dp_status_t   status,
  output qdar_pkg::dp_cmd_t      cmd,
  output logic                   busy
);

  typedef enum logic [27:0] {
    S_IDLE        = 28'h0000001,
    S_DECIDE      = 28'h0000002,
    S_CHKDT       = 28'h0000004,
    S_QMUL        = 28'h0000008,
    S_QFIN        = 28'h0000010,
    S_NORM        = 28'h0000020,
    S_SQ          = 28'h0000040,
    S_SQRT_INIT   = 28'h0000080,
    S_SQRT        = 28'h0000100,
    S_CORD_INIT   = 28'h0000200,
    S_CORDIC      = 28'h0000400,
    S_ZMUL        = 28'h0000800,
    S_RDIV_INIT   = 28'h0001000,
    S_RDIV        = 28'h0002000,
    S_SAVE_R      = 28'h0004000,
    S_UDIV_INIT   = 28'h0008000,
    S_UDIV        = 28'h0010000,
    S_UMUL        = 28'h0020000,
    S_RSAT        = 28'h0040000,
    S_RZERO       = 28'h0080000,
    S_CMUL        = 28'h0100000,
    S_CDIV1_INIT  = 28'h0200000,
    S_CDIV1       = 28'h0400000,
    S_CDIV2_INIT  = 28'h0800000,
    S_CDIV2       = 28'h1000000,
    S_CSAT        = 28'h2000000,
    S_EMIT        = 28'h4000000,
    S_EMIT_D      = 28'h8000000
  } state_t;

  localparam logic [qdar_pkg::CNT_W-1:0] DIV_LAST  = qdar_pkg::CNT_W'(qdar_pkg::DIV_W - 1);
  localparam logic [qdar_pkg::CNT_W-1:0] QMUL_LAST = qdar_pkg::CNT_W'(qdar_pkg::QMUL_TERMS);
  localparam logic [qdar_pkg::CNT_W-1:0] SQRT_LAST =
    qdar_pkg::CNT_W'(qdar_pkg::SQRT_STEPS - 1);
  localparam logic [qdar_pkg::CNT_W-1:0] CORD_LAST =
    qdar_pkg::CNT_W'(qdar_pkg::CORDIC_STEPS - 1);

  state_t                    state, state_next;
  logic [qdar_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [1:0]                ci, ci_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      ci    <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      ci    <= ci_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt + 1'b1;
    ci_next    = ci;
    cmd.op     = qdar_pkg::OP_NONE;
    cmd.idx    = cnt;
    cmd.sel    = ci;
    unique case (state)
      S_IDLE: begin
        cnt_next = '0;
        if (sample_valid) begin
          cmd.op     = qdar_pkg::OP_LOAD;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cnt_next = '0;
        if (!differential_mode) begin
          state_next = S_EMIT_D;
        end else if (status.cov_neg) begin
          state_next = S_IDLE;
        end else begin
          cmd.op     = qdar_pkg::OP_COMMIT;
          state_next = status.have_prev ? S_CHKDT : S_IDLE;
        end
      end
      S_CHKDT: begin
        cnt_next   = '0;
        state_next = status.dt_zero ? S_IDLE : S_QMUL;
      end
      S_QMUL: begin
        if (cnt != QMUL_LAST) cmd.op = qdar_pkg::OP_QMUL;
        if (cnt == QMUL_LAST) begin
          cnt_next   = '0;
          state_next = S_QFIN;
        end
      end
      S_QFIN: begin
        cmd.op     = qdar_pkg::OP_QFIN;
        cnt_next   = '0;
        state_next = S_NORM;
      end
      S_NORM: begin
        cnt_next = '0;
        if (status.vmax_zero) state_next = S_RZERO;
        else if (status.norm_done) state_next = S_SQ;
        else cmd.op = qdar_pkg::OP_NORM;
      end
      S_SQ: begin
        if (cnt != 7'd3) cmd.op = qdar_pkg::OP_SQ;
        else begin
          cnt_next   = '0;
          state_next = S_SQRT_INIT;
        end
      end
      S_SQRT_INIT: begin
        cmd.op     = qdar_pkg::OP_SQRT_INIT;
        cnt_next   = '0;
        state_next = S_SQRT;
      end
      S_SQRT: begin
        cmd.op = qdar_pkg::OP_SQRT;
        if (cnt == SQRT_LAST) begin
          cnt_next   = '0;
          state_next = S_CORD_INIT;
        end
      end
      S_CORD_INIT: begin
        cmd.op     = qdar_pkg::OP_CORDIC_INIT;
        cnt_next   = '0;
        state_next = S_CORDIC;
      end
      S_CORDIC: begin
        cmd.op = qdar_pkg::OP_CORDIC;
        if (cnt == CORD_LAST) begin
          cnt_next   = '0;
          state_next = S_ZMUL;
        end
      end
      S_ZMUL: begin
        if (cnt == 7'd0) cmd.op = qdar_pkg::OP_ZMUL;
        else begin
          cnt_next   = '0;
          state_next = S_RDIV_INIT;
        end
      end
      S_RDIV_INIT: begin
        cmd.op     = qdar_pkg::OP_DIV_R_INIT;
        cnt_next   = '0;
        state_next = S_RDIV;
      end
      S_RDIV: begin
        cmd.op = qdar_pkg::OP_DIV;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = S_SAVE_R;
        end
      end
      S_SAVE_R: begin
        cmd.op     = qdar_pkg::OP_SAVE_R;
        cnt_next   = '0;
        ci_next    = '0;
        state_next = S_UDIV_INIT;
      end
      S_UDIV_INIT: begin
        cmd.op     = qdar_pkg::OP_DIV_U_INIT;
        cnt_next   = '0;
        state_next = S_UDIV;
      end
      S_UDIV: begin
        cmd.op = qdar_pkg::OP_DIV;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = S_UMUL;
        end
      end
      S_UMUL: begin
        if (cnt == 7'd0) cmd.op = qdar_pkg::OP_UMUL_LO;
        else if (cnt == 7'd1) cmd.op = qdar_pkg::OP_UMUL_HI;
        else begin
          cnt_next   = '0;
          state_next = S_RSAT;
        end
      end
      S_RSAT: begin
        cmd.op   = qdar_pkg::OP_RATE_SAT;
        cnt_next = '0;
        if (ci == 2'd2) begin
          ci_next    = '0;
          state_next = S_CMUL;
        end else begin
          ci_next    = ci + 1'b1;
          state_next = S_UDIV_INIT;
        end
      end
      S_RZERO: begin
        cmd.op     = qdar_pkg::OP_RATE_ZERO;
        cnt_next   = '0;
        ci_next    = '0;
        state_next = S_CMUL;
      end
      S_CMUL: begin
        if (cnt == 7'd0) cmd.op = qdar_pkg::OP_CMUL_LO;
        else if (cnt == 7'd1) cmd.op = qdar_pkg::OP_CMUL_HI;
        else begin
          cnt_next   = '0;
          state_next = S_CDIV1_INIT;
        end
      end
      S_CDIV1_INIT: begin
        cmd.op     = qdar_pkg::OP_DIV_C_INIT;
        cnt_next   = '0;
        state_next = S_CDIV1;
      end
      S_CDIV1: begin
        cmd.op = qdar_pkg::OP_DIV;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = S_CDIV2_INIT;
        end
      end
      S_CDIV2_INIT: begin
        cmd.op     = qdar_pkg::OP_DIV_C2_INIT;
        cnt_next   = '0;
        state_next = S_CDIV2;
      end
      S_CDIV2: begin
        cmd.op = qdar_pkg::OP_DIV;
        if (cnt == DIV_LAST) begin
          cnt_next   = '0;
          state_next = S_CSAT;
        end
      end
      S_CSAT: begin
        cmd.op   = qdar_pkg::OP_COV_SAT;
        cnt_next = '0;
        if (ci == 2'd2) begin
          ci_next    = '0;
          state_next = S_EMIT;
        end else begin
          ci_next    = ci + 1'b1;
          state_next = S_CMUL;
        end
      end
      S_EMIT: begin
        cnt_next = '0;
        if (status.out_free) begin
          cmd.op     = qdar_pkg::OP_EMIT;
          state_next = S_IDLE;
        end
      end
      S_EMIT_D: begin
        cnt_next = '0;
        if (status.out_free) begin
          cmd.op     = qdar_pkg::OP_EMIT_DIRECT;
          state_next = S_IDLE;
        end
      end
      default: begin
        cnt_next   = '0;
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

/* rtl/qdar_dp.sv */
module qdar_dp (
  input  logic                  clk,
  input  logic                  rst,
  input  qdar_pkg::dp_cmd_t     cmd,
  output qdar_pkg::dp_status_t  status,
  input  qdar_pkg::sample_t     sample,
  output logic                  result_valid,
  input  logic                  result_stall,
  output qdar_pkg::result_t     result
);

  localparam int QW = qdar_pkg::QUAT_W;
  localparam int DW = qdar_pkg::DATA_W;
  localparam int MW = qdar_pkg::MUL_W;

  // Captured item
  logic        [qdar_pkg::STAMP_W-1:0] stamp;
  logic signed [QW-1:0]                cq      [4];
  logic signed [DW-1:0]                cov_in  [3];
  logic signed [DW-1:0]                rate_in [3];

  // Differential state
  logic signed [QW-1:0]                prev_q  [4];
  logic        [qdar_pkg::STAMP_W-1:0] prev_stamp;
  logic                                have_prev;

  // Working registers
  logic signed [QW-1:0]                pq      [4];
  logic        [qdar_pkg::STAMP_W-1:0] dt;
  logic signed [DW-1:0]                dq      [4];
  logic        [qdar_pkg::VA_W-1:0]    va      [3];
  logic                                vneg    [3];
  logic signed [qdar_pkg::XY_W-1:0]    x, y;
  logic signed [qdar_pkg::Z_W-1:0]     z;
  logic signed [qdar_pkg::PROD_W-1:0]  prod;
  qdar_pkg::ptag_t                     ptag;
  logic        [qdar_pkg::SQRT_IN_W-1:0] sum;
  logic        [qdar_pkg::ACC_W-1:0]   acc;
  logic        [qdar_pkg::SQRT_IN_W-1:0] rad;
  logic        [32:0]                  srem;
  logic        [qdar_pkg::ROOT_W-1:0]  root;
  logic        [qdar_pkg::DIV_W-1:0]   div_q;
  logic        [qdar_pkg::STAMP_W-1:0] div_rem;
  logic        [qdar_pkg::STAMP_W-1:0] div_d;
  logic        [qdar_pkg::R_W-1:0]     r;
  logic        [DW-1:0]                rate_o  [3];
  logic        [qdar_pkg::COV_OUT_W-1:0] cov_o [3];

  // Multiplier operand selection
  logic signed [MW-1:0]       ma, mb;
  qdar_pkg::ptag_t            tag_new;
  qdar_pkg::qterm_t           qt;
  logic        [DW-1:0]       cmag;
  logic        [33:0]         zc;

  assign qt = qdar_pkg::qterm(cmd.idx[3:0]);
  assign cmag = cov_in[cmd.sel][DW-1] ? DW'(-cov_in[cmd.sel]) : cov_in[cmd.sel];
  assign zc = z[qdar_pkg::Z_W-1] ? '0 : z[33:0];

  always_comb begin
    ma      = '0;
    mb      = '0;
    tag_new = '{kind: qdar_pkg::T_NONE, comp: 2'd0, neg: 1'b0};
    case (cmd.op)
      qdar_pkg::OP_QMUL: begin
        ma      = MW'(pq[qt.pi]);
        mb      = MW'(cq[qt.ci]);
        tag_new = '{kind: qdar_pkg::T_DQ, comp: cmd.idx[3:2], neg: qt.neg};
      end
      qdar_pkg::OP_SQ: begin
        ma      = MW'(va[cmd.idx[1:0]]);
        mb      = MW'(va[cmd.idx[1:0]]);
        tag_new.kind = qdar_pkg::T_SUM;
      end
      qdar_pkg::OP_ZMUL: begin
        ma      = MW'(zc);
        mb      = qdar_pkg::US_PER_S;
        tag_new.kind = qdar_pkg::T_SET;
      end
      qdar_pkg::OP_UMUL_LO: begin
        ma      = MW'(r[qdar_pkg::MUL_SPLIT-1:0]);
        mb      = MW'(div_q[qdar_pkg::U_W-1:0]);
        tag_new.kind = qdar_pkg::T_SET;
      end
      qdar_pkg::OP_UMUL_HI: begin
        ma      = MW'(r[qdar_pkg::R_W-1:qdar_pkg::MUL_SPLIT]);
        mb      = MW'(div_q[qdar_pkg::U_W-1:0]);
        tag_new.kind = qdar_pkg::T_ADDHI;
      end
      qdar_pkg::OP_CMUL_LO: begin
        ma      = MW'(cmag);
        mb      = MW'(qdar_pkg::COV_GAIN[qdar_pkg::MUL_SPLIT-1:0]);
        tag_new.kind = qdar_pkg::T_SET;
      end
      qdar_pkg::OP_CMUL_HI: begin
        ma      = MW'(cmag);
        mb      = MW'(qdar_pkg::COV_GAIN[40:qdar_pkg::MUL_SPLIT]);
        tag_new.kind = qdar_pkg::T_ADDHI;
      end
      default: ;
    endcase
  end

  // Sign flip so that w >= 0, then magnitudes of the vector part.
  logic signed [DW-1:0] dflip [3];
  logic        [DW-1:0] dabs  [3];
  logic        [DW-1:0] wabs;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dflip[i] = dq[3][DW-1] ? -dq[i] : dq[i];
      dabs[i]  = dflip[i][DW-1] ? DW'(-dflip[i]) : DW'(dflip[i]);
    end
    wabs = dq[3][DW-1] ? DW'(-dq[3]) : DW'(dq[3]);
  end

  logic [qdar_pkg::VA_W-1:0] vmax;

  always_comb begin
    vmax = va[0];
    if (va[1] > vmax) vmax = va[1];
    if (va[2] > vmax) vmax = va[2];
  end

  // Square root digit step
  logic [34:0] sq_rem_t, sq_trial, sq_diff;
  logic        sq_ge;

  assign sq_rem_t = {srem, rad[qdar_pkg::SQRT_IN_W-1 -: 2]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_ge    = (sq_rem_t >= sq_trial);
  assign sq_diff  = sq_rem_t - sq_trial;

  // Divider bit step
  logic [qdar_pkg::STAMP_W:0] dv_sh, dv_diff;
  logic                       dv_ge;

  assign dv_sh   = {div_rem, div_q[qdar_pkg::DIV_W-1]};
  assign dv_ge   = (dv_sh >= {1'b0, div_d});
  assign dv_diff = dv_sh - {1'b0, div_d};

  // CORDIC step
  logic [4:0]                       ck;
  logic signed [qdar_pkg::XY_W-1:0] xs, ys;
  logic signed [qdar_pkg::Z_W-1:0]  ang;

  assign ck  = cmd.idx[4:0];
  assign xs  = x >>> ck;
  assign ys  = y >>> ck;
  assign ang = qdar_pkg::Z_W'(qdar_pkg::ATAN_LUT[ck]);

  // Saturation of the current rate and covariance
  logic [40:0]                 rmag;
  logic [32:0]                 rlim;
  logic [31:0]                 rsat;
  logic [qdar_pkg::COV_OUT_W:0] clim;
  logic [qdar_pkg::COV_OUT_W-1:0] csat;
  logic                        cneg;

  assign rmag = acc[qdar_pkg::ACC_W-1:qdar_pkg::RATE_SHIFT];
  assign rlim = vneg[cmd.sel] ? 33'h080000000 : 33'h07FFFFFFF;
  assign rsat = (rmag > 41'(rlim)) ? rlim[31:0] : rmag[31:0];
  assign cneg = cov_in[cmd.sel][DW-1];
  assign clim = cneg ? (49'd1 << (qdar_pkg::COV_OUT_W - 1))
                     : ((49'd1 << (qdar_pkg::COV_OUT_W - 1)) - 49'd1);
  assign csat = (div_q > qdar_pkg::DIV_W'(clim)) ? clim[qdar_pkg::COV_OUT_W-1:0]
                                                 : div_q[qdar_pkg::COV_OUT_W-1:0];

  logic signed [DW-1:0] p32;
  assign p32 = prod[DW-1:0];

  logic out_free;
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      have_prev    <= 1'b0;
      prev_stamp   <= '0;
      for (int i = 0; i < 4; i++) prev_q[i] <= '0;
      ptag.kind    <= qdar_pkg::T_NONE;
      result_valid <= 1'b0;
    end else begin
      prod <= ma * mb;
      ptag <= tag_new;

      case (ptag.kind)
        qdar_pkg::T_DQ:
          dq[ptag.comp] <= ptag.neg ? dq[ptag.comp] - p32 : dq[ptag.comp] + p32;
        qdar_pkg::T_SUM:   sum <= sum + prod[qdar_pkg::SQRT_IN_W-1:0];
        qdar_pkg::T_SET:   acc <= qdar_pkg::ACC_W'(prod);
        qdar_pkg::T_ADDHI: acc <= acc + {prod[45:0], 34'd0};
        default: ;
      endcase

      if (cmd.op == qdar_pkg::OP_EMIT || cmd.op == qdar_pkg::OP_EMIT_DIRECT) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end

      case (cmd.op)
        qdar_pkg::OP_LOAD: begin
          stamp      <= sample.stamp_us;
          cq[0]      <= qdar_pkg::clamp_q(sample.quat_x);
          cq[1]      <= qdar_pkg::clamp_q(sample.quat_y);
          cq[2]      <= qdar_pkg::clamp_q(sample.quat_z);
          cq[3]      <= qdar_pkg::clamp_q(sample.quat_w);
          cov_in[0]  <= sample.cov_first;
          cov_in[1]  <= sample.cov_second;
          cov_in[2]  <= sample.cov_third;
          rate_in[0] <= sample.rate_in_x;
          rate_in[1] <= sample.rate_in_y;
          rate_in[2] <= sample.rate_in_z;
        end
        qdar_pkg::OP_COMMIT: begin
          for (int i = 0; i < 4; i++) begin
            pq[i]     <= prev_q[i];
            prev_q[i] <= cq[i];
            dq[i]     <= '0;
          end
          dt         <= (stamp > prev_stamp) ? stamp - prev_stamp : '0;
          prev_stamp <= stamp;
          have_prev  <= 1'b1;
        end
        qdar_pkg::OP_QFIN: begin
          for (int i = 0; i < 3; i++) begin
            vneg[i] <= dflip[i][DW-1];
            va[i]   <= dabs[i][qdar_pkg::VA_W-1:0];
          end
          x   <= qdar_pkg::XY_W'(wabs);
          sum <= '0;
        end
        qdar_pkg::OP_NORM: begin
          for (int i = 0; i < 3; i++) va[i] <= va[i] << 1;
          x <= x <<< 1;
        end
        qdar_pkg::OP_SQRT_INIT: begin
          rad  <= sum;
          srem <= '0;
          root <= '0;
        end
        qdar_pkg::OP_SQRT: begin
          srem <= sq_ge ? sq_diff[32:0] : sq_rem_t[32:0];
          root <= {root[qdar_pkg::ROOT_W-2:0], sq_ge};
          rad  <= rad << 2;
        end
        qdar_pkg::OP_CORDIC_INIT: begin
          y <= qdar_pkg::XY_W'(root);
          z <= '0;
        end
        qdar_pkg::OP_CORDIC: begin
          if (!y[qdar_pkg::XY_W-1]) begin
            x <= x + ys;
            y <= y - xs;
            z <= z + ang;
          end else begin
            x <= x - ys;
            y <= y + xs;
            z <= z - ang;
          end
        end
        qdar_pkg::OP_DIV_R_INIT: begin
          div_q   <= acc[qdar_pkg::DIV_W-1:0];
          div_d   <= dt;
          div_rem <= '0;
        end
        qdar_pkg::OP_DIV_U_INIT: begin
          div_q   <= {17'd0, va[cmd.sel], 24'd0};
          div_d   <= qdar_pkg::STAMP_W'(root);
          div_rem <= '0;
        end
        qdar_pkg::OP_DIV_C_INIT: begin
          div_q   <= acc[qdar_pkg::DIV_W-1:0];
          div_d   <= dt;
          div_rem <= '0;
        end
        qdar_pkg::OP_DIV_C2_INIT: begin
          div_rem <= '0;
        end
        qdar_pkg::OP_DIV: begin
          div_q   <= {div_q[qdar_pkg::DIV_W-2:0], dv_ge};
          div_rem <= dv_ge ? dv_diff[qdar_pkg::STAMP_W-1:0] : dv_sh[qdar_pkg::STAMP_W-1:0];
        end
        qdar_pkg::OP_SAVE_R: begin
          r <= div_q[qdar_pkg::R_W-1:0];
        end
        qdar_pkg::OP_RATE_SAT: begin
          rate_o[cmd.sel] <= vneg[cmd.sel] ? 32'(-rsat) : rsat;
        end
        qdar_pkg::OP_RATE_ZERO: begin
          for (int i = 0; i < 3; i++) rate_o[i] <= '0;
        end
        qdar_pkg::OP_COV_SAT: begin
          cov_o[cmd.sel] <= cneg ? qdar_pkg::COV_OUT_W'(-csat) : csat;
        end
        qdar_pkg::OP_EMIT: begin
          result.out_stamp_us <= stamp;
          result.rate_out_x   <= rate_o[0];
          result.rate_out_y   <= rate_o[1];
          result.rate_out_z   <= rate_o[2];
          result.rate_cov_x   <= cov_o[0];
          result.rate_cov_y   <= cov_o[1];
          result.rate_cov_z   <= cov_o[2];
        end
        qdar_pkg::OP_EMIT_DIRECT: begin
          result.out_stamp_us <= stamp;
          result.rate_out_x   <= rate_in[0];
          result.rate_out_y   <= rate_in[1];
          result.rate_out_z   <= rate_in[2];
          result.rate_cov_x   <= qdar_pkg::COV_OUT_W'(cov_in[0]);
          result.rate_cov_y   <= qdar_pkg::COV_OUT_W'(cov_in[1]);
          result.rate_cov_z   <= qdar_pkg::COV_OUT_W'(cov_in[2]);
        end
        default: ;
      endcase
    end
  end

  assign status.cov_neg   = cov_in[0][DW-1];
  assign status.have_prev = have_prev;
  assign status.dt_zero   = (dt == '0);
  assign status.vmax_zero = (vmax == '0);
  assign status.norm_done = vmax[qdar_pkg::VA_W-1] | vmax[qdar_pkg::VA_W-2];
  assign status.out_free  = out_free;

endmodule

/* rtl/quaternion_delta_angular_rate_unit.sv */
// Channel   Direction  Handshake                   Payload
// sample    in         sample_valid / sample_stall  qdar_pkg::sample_t
// result    out        result_valid / result_stall  qdar_pkg::result_t
// config    in         APB write/read, pready = 1   differential_mode at byte address 0
//
// A direct-mode item passes the decide and direct-emit states; its result goes
// to the output register once that register is free. A differential item is
// dominated by the one-bit-per-cycle divider: ten 72-bit divisions per item
// (rate scale, three unit-vector terms and two for each of three covariance
// terms), plus normalization, 31 square-root and 32 CORDIC steps. Dropped or
// stored-only items end at the decide state, a non-increasing stamp at the
// interval check. One item is worked at a time; sample_stall is high from accept
// until the item is finished and its result, if any, is in the output register.
// The output register lets the next item be accepted while a result waits on
// result_stall. Reset (rst, synchronous) clears the mode register and the stored
// orientation state.
module quaternion_delta_angular_rate_unit (
  input  logic                          clk,
  input  logic                          rst,

  input  logic                          sample_valid,
  output logic                          sample_stall,
  input  qdar_pkg::sample_t             sample,

  output logic                          result_valid,
  input  logic                          result_stall,
  output qdar_pkg::result_t             result,

  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qdar_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  // The one configuration register selects how the rate is produced.
  logic differential_mode;
  logic reg_hit;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[qdar_pkg::ADDR_W-1:2] == qdar_pkg::REG_DIFF_MODE);

  always_ff @(posedge clk) begin
    if (rst) begin
      differential_mode <= 1'b0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      differential_mode <= pwdata[0];
    end
  end

  assign prdata = reg_hit ? {31'd0, differential_mode} : 32'd0;

  // The controller sequences the shared multiplier, square root, CORDIC and
  // divider steps; the datapath holds every operand, the stored orientation
  // and the output register.
  qdar_pkg::dp_cmd_t    cmd;
  qdar_pkg::dp_status_t status;

  qdar_ctrl u_ctrl (
    .clk               (clk),
    .rst               (rst),
    .sample_valid      (sample_valid),
    .differential_mode (differential_mode),
    .status            (status),
    .cmd               (cmd),
    .busy              (sample_stall)
  );

  qdar_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule

/* bench/tb_top.sv */
module tb_top;
  import qdar_pkg::*;

  // The clock, the reset and every input of the block start at a known value.
  logic clk = 1'b0;
  logic rst = 1'b1;

  logic sample_valid = 1'b0;
  logic sample_stall;
  sample_t sample = '0;

  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;

  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  localparam longint unsigned CYCLE_LIMIT = 64'd5_000_000;
  localparam longint unsigned MICROS_PER_SECOND = 64'd1_000_000;
  localparam longint unsigned COV_SCALE = 64'd2_000_000_000_000;
  localparam int LONG_HOLD = 2000;
  // A dropped, stored-only or zero-interval item produces nothing but still keeps
  // the block busy until it ends; this many cycles is ample for it to go idle.
  localparam int SETTLE_CYCLES = 100;

  quaternion_delta_angular_rate_unit DUT (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample(sample),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result(result),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #5 clk = ~clk;

  // Our own copy of the block's state and of its mode register.
  bit diff_mode = 1'b0;
  bit have_prev = 1'b0;
  longint prev_quat[4] = '{0, 0, 0, 0};
  longint unsigned prev_stamp = 0;

  // Rates still owed by the block, oldest first.
  result_t pending_rates[$];
  int mismatches = 0;
  longint unsigned cycles = 0;

  // When set, both sides run without gaps.
  bit calm = 1'b0;
  // Each bump of the ticket asks the receiver for one long hold-off.
  int hold_ticket = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_left = 0;

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  function automatic longint clamp_comp(input logic signed [QUAT_W-1:0] v);
    longint t;
    t = v;
    if (t > 16384) t = 16384;
    if (t < -16384) t = -16384;
    return t;
  endfunction

  // atan(2^-k) in units of 2^-32 rad. Beyond the first step the angle comes
  // from the alternating arctangent series in Q0.62, rounded half up.
  function automatic longint arctan_step(input int k);
    longint unsigned acc;
    longint unsigned term;
    int j;
    int e;
    if (k == 0) return 64'd3373259426;
    acc = 0;
    j = 0;
    e = k;
    while (e <= 62) begin
      term = (64'd1 << (62 - e)) / 64'(2 * j + 1);
      if (j % 2 == 1) acc = acc - term;
      else acc = acc + term;
      j++;
      e = k * (2 * j + 1);
    end
    return longint'((acc + (64'd1 << 29)) >> 30);
  endfunction

  // Floor of the square root, one result bit at a time.
  function automatic longint unsigned floor_sqrt(input longint unsigned s);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= s) root = trial;
    end
    return root;
  endfunction

  // Signed saturation of a magnitude to a w-bit two's complement value.
  function automatic logic [63:0] saturate(input logic [127:0] mag, input bit neg,
                                           input int w);
    logic [127:0] lim;
    lim = neg ? (128'd1 << (w - 1)) : (128'd1 << (w - 1)) - 1;
    if (mag > lim) mag = lim;
    return neg ? -mag[63:0] : mag[63:0];
  endfunction

  // Works out the result of one accepted sample and advances the stored state.
  // Returns 1 when the block owes a result for it.
  function automatic bit predict_rate(input sample_t s, output result_t r);
    longint c[4];
    longint p[4];
    longint d[4];
    longint cov[3];
    longint x;
    longint y;
    longint z;
    longint xn;
    longint a;
    longint unsigned va[3];
    longint unsigned vmax;
    longint unsigned sum;
    longint unsigned n;
    longint unsigned scale;
    longint unsigned u;
    longint unsigned dt;
    longint unsigned m;
    logic [127:0] wide;
    logic [63:0] rate[3];
    logic [63:0] rcov[3];
    int sh;
    r = '0;
    r.out_stamp_us = s.stamp_us;
    if (!diff_mode) begin
      r.rate_out_x = s.rate_in_x;
      r.rate_out_y = s.rate_in_y;
      r.rate_out_z = s.rate_in_z;
      r.rate_cov_x = s.cov_first;
      r.rate_cov_y = s.cov_second;
      r.rate_cov_z = s.cov_third;
      return 1'b1;
    end
    cov[0] = s.cov_first;
    cov[1] = s.cov_second;
    cov[2] = s.cov_third;
    if (cov[0] < 0) return 1'b0;
    c[0] = clamp_comp(s.quat_x);
    c[1] = clamp_comp(s.quat_y);
    c[2] = clamp_comp(s.quat_z);
    c[3] = clamp_comp(s.quat_w);
    if (!have_prev) begin
      prev_quat = c;
      prev_stamp = s.stamp_us;
      have_prev = 1'b1;
      return 1'b0;
    end
    dt = (s.stamp_us > prev_stamp) ? s.stamp_us - prev_stamp : 0;
    p = prev_quat;
    prev_quat = c;
    prev_stamp = s.stamp_us;
    if (dt == 0) return 1'b0;

    // Rotation from the previous to the current orientation, conj(p) * c.
    d[0] = p[3] * c[0] - p[0] * c[3] - p[1] * c[2] + p[2] * c[1];
    d[1] = p[3] * c[1] + p[0] * c[2] - p[1] * c[3] - p[2] * c[0];
    d[2] = p[3] * c[2] - p[0] * c[1] + p[1] * c[0] - p[2] * c[3];
    d[3] = p[3] * c[3] + p[0] * c[0] + p[1] * c[1] + p[2] * c[2];
    if (d[3] < 0) for (int i = 0; i < 4; i++) d[i] = -d[i];

    vmax = 0;
    for (int i = 0; i < 3; i++) begin
      va[i] = (d[i] < 0) ? -d[i] : d[i];
      if (va[i] > vmax) vmax = va[i];
      rate[i] = '0;
    end
    if (vmax != 0) begin
      sh = 0;
      while ((vmax << sh) < (64'd1 << 29)) sh++;
      sum = 0;
      for (int i = 0; i < 3; i++) begin
        va[i] = va[i] << sh;
        sum = sum + va[i] * va[i];
      end
      n = floor_sqrt(sum);
      // Vectoring CORDIC gives the half angle atan2(|v|, w).
      x = d[3] <<< sh;
      y = longint'(n);
      z = 0;
      for (int k = 0; k < CORDIC_STEPS; k++) begin
        a = arctan_step(k);
        if (y >= 0) begin
          xn = x + (y >>> k);
          y = y - (x >>> k);
          z = z + a;
        end else begin
          xn = x - (y >>> k);
          y = y + (x >>> k);
          z = z - a;
        end
        x = xn;
      end
      if (z < 0) z = 0;
      scale = longint'(z) * MICROS_PER_SECOND / dt;
      for (int i = 0; i < 3; i++) begin
        u = (va[i] << 24) / n;
        wide = 128'(scale) * 128'(u);
        rate[i] = saturate(wide >> 39, d[i] < 0, DATA_W);
      end
    end

    // Covariance of the rate: 2 * C / dt^2, with dt in microseconds.
    for (int i = 0; i < 3; i++) begin
      m = (cov[i] < 0) ? -cov[i] : cov[i];
      wide = 128'(m) * 128'(COV_SCALE);
      wide = wide / 128'(dt);
      wide = wide / 128'(dt);
      rcov[i] = saturate(wide, cov[i] < 0, COV_OUT_W);
    end
    r.rate_out_x = rate[0][DATA_W-1:0];
    r.rate_out_y = rate[1][DATA_W-1:0];
    r.rate_out_z = rate[2][DATA_W-1:0];
    r.rate_cov_x = rcov[0][COV_OUT_W-1:0];
    r.rate_cov_y = rcov[1][COV_OUT_W-1:0];
    r.rate_cov_z = rcov[2][COV_OUT_W-1:0];
    return 1'b1;
  endfunction

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s expected %0d got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Every accepted result is matched against the oldest owed result.
  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_rates.size() == 0) begin
        $error("result with stamp %0d arrived with nothing owed", result.out_stamp_us);
        mismatches++;
      end else begin
        want = pending_rates.pop_front();
        check_field("out_stamp_us", want.out_stamp_us, result.out_stamp_us);
        check_field("rate_out_x", want.rate_out_x, result.rate_out_x);
        check_field("rate_out_y", want.rate_out_y, result.rate_out_y);
        check_field("rate_out_z", want.rate_out_z, result.rate_out_z);
        check_field("rate_cov_x", want.rate_cov_x, result.rate_cov_x);
        check_field("rate_cov_y", want.rate_cov_y, result.rate_cov_y);
        check_field("rate_cov_z", want.rate_cov_z, result.rate_cov_z);
      end
    end
  end

  // The receiving side: random stalls, plus a long hold-off whenever a test asks.
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left = 0;
    end else if (hold_served != hold_ticket) begin
      hold_served = hold_ticket;
      hold_left = LONG_HOLD;
      result_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
      stall_left = pick_gap();
    end
  end

  // A run that takes far longer than the slowest correct one is a failure.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offers one item after a random gap and holds it until the block takes it.
  // Valid stays high across back-to-back items, so it only drops for a real gap.
  task automatic send_sample(input sample_t s);
    int gap;
    result_t r;
    gap = pick_gap();
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    do @(posedge clk); while (sample_stall);
    if (predict_rate(s, r)) pending_rates.push_back(r);
  endtask

  // Stops offering, then waits until every owed result is in and the block has
  // had time to finish any item that produces nothing.
  task automatic drain();
    sample_valid <= 1'b0;
    while (pending_rates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup cycle, then access cycle. Only called while idle.
  task automatic write_mode(input bit mode);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= ADDR_W'(REG_DIFF_MODE) << 2;
    pwdata <= {31'd0, mode};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    diff_mode = mode;
  endtask

  function automatic sample_t make_sample(input longint qx, input longint qy,
                                          input longint qz, input longint qw,
                                          input longint unsigned stamp,
                                          input longint c0, input longint c1,
                                          input longint c2);
    sample_t s;
    s.quat_x = qx[15:0];
    s.quat_y = qy[15:0];
    s.quat_z = qz[15:0];
    s.quat_w = qw[15:0];
    s.stamp_us = stamp[STAMP_W-1:0];
    s.cov_first = c0[31:0];
    s.cov_second = c1[31:0];
    s.cov_third = c2[31:0];
    s.rate_in_x = $urandom;
    s.rate_in_y = $urandom;
    s.rate_in_z = $urandom;
    return s;
  endfunction

  // Direct mode after reset: rates and covariances pass through untouched,
  // including the extremes and negative covariances that must sign-extend.
  task automatic test_direct_extremes();
    sample_t s;
    s = make_sample(0, 0, 0, 0, 0, 32'sh7fffffff, -2147483648, -1);
    s.rate_in_x = 32'sh7fffffff;
    s.rate_in_y = 32'sh80000000;
    s.rate_in_z = 32'sh00000000;
    send_sample(s);
    s = make_sample(-32768, 32767, -1, 16384, 40'hff_ffff_ffff, -2147483648,
                    2147483647, 0);
    s.rate_in_x = -1;
    send_sample(s);
    s = make_sample(1, 2, 3, 4, 12345, 1, 0, 32'sh7fffffff);
    send_sample(s);
    drain();
  endtask

  // Differential mode special cases, one after another on a single state.
  task automatic test_differential_cases();
    write_mode(1'b1);
    // Negative orientation covariance: dropped before anything is stored.
    send_sample(make_sample(0, 0, 0, 16384, 500, -1, 5, 5));
    // First usable sample is only stored.
    send_sample(make_sample(0, 0, 0, 16384, 1000, 100, 200, 300));
    // Same orientation again: zero rotation, covariance still reported.
    send_sample(make_sample(0, 0, 0, 16384, 2000, 1000, 2000, 3000));
    // A quarter turn about z in one millisecond.
    send_sample(make_sample(0, 0, 11585, 11585, 3000, 2147483647, 0, -7));
    // Repeated and then earlier stamps: state moves, nothing is reported.
    send_sample(make_sample(11585, 0, 0, 11585, 3000, 0, 0, 0));
    send_sample(make_sample(0, 11585, 0, -11585, 2500, 0, 0, 0));
    // Components beyond one are clamped before use.
    send_sample(make_sample(32767, -32768, 20000, -20000, 4000, 5, 6, 7));
    // A zero quaternion gives a zero vector part.
    send_sample(make_sample(0, 0, 0, 0, 5000, 9, 9, 9));
    send_sample(make_sample(-16384, 0, 0, 0, 6000, 9, -9, 9));
    // A one-microsecond step saturates the covariance and the rate.
    send_sample(make_sample(0, 16384, 0, 0, 6001, 2147483647, -2147483648, 1));
    // Opposite hemisphere: the delta is flipped to keep w non-negative.
    send_sample(make_sample(100, -16000, 50, -3000, 6500, 77, 88, 99));
    send_sample(make_sample(1, 1, 1, 1, 6700, 0, 0, 0));
    // The largest stamp gives the longest interval.
    send_sample(make_sample(-5, 8000, -8000, 11000, 40'hff_ffff_ffff, 2147483647,
                            2147483647, -2147483648));
    drain();
  endtask

  // The stored orientation survives a trip through direct mode.
  task automatic test_mode_switch();
    write_mode(1'b0);
    send_sample(make_sample(3, 4, 5, 6, 10, 11, 12, 13));
    send_sample(make_sample(3, 4, 5, 6, 20, -11, -12, -13));
    drain();
    write_mode(1'b1);
    // Earlier than the stored stamp: only the state moves.
    send_sample(make_sample(0, 0, 0, 16384, 1000, 1, 1, 1));
    send_sample(make_sample(0, 200, 0, 16380, 1700, 1, 2, 3));
    drain();
  endtask

  // Random differential traffic: mostly smooth trajectories with increasing
  // stamps, mixed with wild orientations, bad covariances and stamp jumps.
  task automatic test_random_differential(input int count);
    sample_t s;
    longint q[4];
    longint unsigned stamp;
    int roll;
    write_mode(1'b1);
    q = '{0, 0, 0, 16384};
    stamp = 64'd1000;
    for (int i = 0; i < count; i++) begin
      calm = (i / 60) % 3 == 2;
      roll = $urandom_range(0, 99);
      if (roll < 3) stamp = stamp - $urandom_range(0, 50);
      else if (roll < 6) stamp = {$urandom_range(0, 255), $urandom} & 64'hff_ffff_ffff;
      else if (roll < 9) stamp = stamp + 1;
      else stamp = stamp + $urandom_range(1, 20000);
      if (stamp > 64'hff_ffff_ffff) stamp = $urandom_range(0, 1000);
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        for (int j = 0; j < 4; j++) q[j] = longint'($signed(16'($urandom)));
      end else if (roll < 20) begin
        for (int j = 0; j < 4; j++) q[j] = -q[j];
      end else begin
        for (int j = 0; j < 4; j++) begin
          q[j] = q[j] + $urandom_range(0, 4000) - 2000;
          if (q[j] > 16384) q[j] = 16384;
          if (q[j] < -16384) q[j] = -16384;
        end
      end
      s = make_sample(q[0], q[1], q[2], q[3], stamp, longint'($urandom & 32'h7fffffff),
                      longint'($signed($urandom)), longint'($signed($urandom)));
      if ($urandom_range(0, 99) < 5) s.cov_first = $urandom | 32'h80000000;
      send_sample(s);
    end
    calm = 1'b0;
    drain();
  endtask

  // The receiver holds off for a long stretch while items keep coming, so the
  // output register fills and the block must stall its input.
  task automatic test_backpressure();
    sample_t s;
    write_mode(1'b0);
    calm = 1'b1;
    hold_ticket++;
    for (int i = 0; i < 30; i++) begin
      s = make_sample($urandom, $urandom, $urandom, $urandom,
                      {$urandom_range(0, 255), $urandom}, $signed($urandom),
                      $signed($urandom), $signed($urandom));
      send_sample(s);
    end
    calm = 1'b0;
    drain();
  endtask

  task automatic test_random_direct(input int count);
    sample_t s;
    for (int i = 0; i < count; i++) begin
      calm = (i / 50) % 4 == 3;
      s = make_sample($urandom, $urandom, $urandom, $urandom,
                      {$urandom_range(0, 255), $urandom}, $signed($urandom),
                      $signed($urandom), $signed($urandom));
      send_sample(s);
    end
    calm = 1'b0;
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_direct_extremes();
    test_differential_cases();
    test_mode_switch();
    test_random_differential(450);
    test_backpressure();
    test_random_direct(400);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/qdar_pkg.sv
rtl/qdar_ctrl.sv
rtl/qdar_dp.sv
rtl/quaternion_delta_angular_rate_unit.sv
bench/tb_top.sv
